// ===== rtl/ssfs_pkg.sv =====
// Package with the types, codes and constants of the spherical segment fill solver.
`default_nettype none
package ssfs_pkg;

  localparam int LEN_W            = 24;
  localparam int VOL_W            = 48;
  localparam int TOL_W            = 16;
  localparam int LENGTH_FRAC_BITS = 12;
  localparam int BISECT_PASSES    = 24;
  localparam int DIV_W            = 2 * LEN_W + 1;
  localparam int S_W              = 53;
  localparam logic [31:0] PI_SIXTH_Q32 = 32'd2248839617;

  typedef enum logic [1:0] {
    REG_BASE_RADIUS = 2'd0,
    REG_TOP_RADIUS  = 2'd1,
    REG_HEIGHT      = 2'd2,
    REG_TOLERANCE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_FWD = 2'd0,
    PH_MAX = 2'd1,
    PH_BIS = 2'd2
  } phase_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RB, ST_RT, ST_HH, ST_MAG, ST_DIVQ,
    ST_EHH, ST_EQL, ST_EQH, ST_ERH, ST_ELD, ST_EDIV,
    ST_EA2, ST_ES, ST_EGL, ST_EGH, ST_EG, ST_EVL, ST_EVH, ST_EV,
    ST_CHECK, ST_OUT
  } state_t;

  typedef struct packed {
    logic             func;
    logic [LEN_W-1:0] height_in;
    logic [VOL_W-1:0] volume_in;
  } in_t;

  typedef struct packed {
    logic [VOL_W-1:0] fill_volume;
    logic [LEN_W-1:0] fill_height;
    logic             clamped;
    logic             converged;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/spherical_segment_fill_solver_unit.sv =====
// Top level of the spherical segment fill solver with its sequencer and shared units.
//
// Input beats arrive on in_valid/in_stall with an in_data payload and each gives
// exactly one result beat on out_valid/out_stall. One item is worked on at a time;
// in_stall stays high from acceptance until the result has been written to the
// output register. A volume query runs the setup and one volume evaluation; a
// height query adds one evaluation for each bisection pass, up to 24 passes.
// The run time is set by the one-bit-per-cycle restoring divider, used in the
// setup and in every volume evaluation, and by the single 32 by 32 bit
// multiplier that every wide product goes through in turn.
// Registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is
// high only while the sequencer is idle and no input beat is offered.
// A synchronous reset loads the register defaults, empties the output register
// and returns the sequencer to idle.
// When the receiver stalls, the result beat holds in the output register; the next
// item is still taken, and its result waits in the output state until that has gone.
`default_nettype none
module spherical_segment_fill_solver_unit #(
  parameter int BISECT_PASSES = ssfs_pkg::BISECT_PASSES
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire ssfs_pkg::in_t           in_data,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output ssfs_pkg::out_t               out_data,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [ssfs_pkg::LEN_W-1:0] cfg_data
);

  localparam int LW    = ssfs_pkg::LEN_W;
  localparam int VW    = ssfs_pkg::VOL_W;
  localparam int DW    = ssfs_pkg::DIV_W;
  localparam int SW    = ssfs_pkg::S_W;
  localparam int PASS_W = $clog2(BISECT_PASSES + 1);
  localparam int CNT_W = $clog2(DW);

  ssfs_pkg::state_t state, state_next;
  ssfs_pkg::phase_t phase;

  logic [LW-1:0] base_radius, top_radius, height_limit;
  logic [ssfs_pkg::TOL_W-1:0] volume_tolerance;

  logic [31:0] ma, mb;
  logic [63:0] preg;

  logic [DW-1:0] dvd;
  logic [LW-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [LW+1:0] trial;
  logic [LW-1:0] rem_step;
  logic [DW-1:0] dvd_step;
  logic div_last;

  logic [2*LW-1:0] rb2, rt2, hh;
  logic [DW-1:0] up, q;
  logic [LW-1:0] r;
  logic neg;
  logic [DW:0] tacc;
  logic [DW:0] a2;
  logic [SW-1:0] s, g;
  logic [63:0] gacc, vacc;
  logic [VW-1:0] v, vq;
  logic [LW-1:0] cur_h, lo, hi;
  logic [PASS_W-1:0] pass;
  logic clamped_r;
  ssfs_pkg::out_t res;

  logic [DW:0] mag_c;
  logic [DW+2:0] a2_c;
  logic [DW+1:0] t_c;
  logic [95:0] full_c;
  logic [VW-1:0] err_c;
  logic [LW-1:0] lo_c, hi_c;
  logic [LW:0] sum_c;
  logic hit_c;

  assign cfg_ready = (state == ssfs_pkg::ST_IDLE) && !in_valid;
  assign in_stall  = (state != ssfs_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_radius      <= LW'(4096);
      top_radius       <= LW'(4096);
      height_limit     <= LW'(4096);
      volume_tolerance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ssfs_pkg::reg_idx_t'(cfg_index))
        ssfs_pkg::REG_BASE_RADIUS: base_radius      <= cfg_data;
        ssfs_pkg::REG_TOP_RADIUS:  top_radius       <= cfg_data;
        ssfs_pkg::REG_HEIGHT:      height_limit     <= cfg_data;
        ssfs_pkg::REG_TOLERANCE:   volume_tolerance <= cfg_data[ssfs_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Restoring divider step by height_limit.
  always_comb begin
    trial    = {1'b0, rem, dvd[DW-1]} - {2'b00, height_limit};
    rem_step = trial[LW+1] ? {rem[LW-2:0], dvd[DW-1]} : trial[LW-1:0];
    dvd_step = {dvd[DW-2:0], ~trial[LW+1]};
    div_last = (cnt == CNT_W'(DW - 1));
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ssfs_pkg::ST_RB:  begin ma = 32'(base_radius); mb = 32'(base_radius); end
      ssfs_pkg::ST_RT:  begin ma = 32'(top_radius); mb = 32'(top_radius); end
      ssfs_pkg::ST_HH:  begin ma = 32'(height_limit); mb = 32'(height_limit); end
      ssfs_pkg::ST_EHH: begin ma = 32'(cur_h); mb = 32'(cur_h); end
      ssfs_pkg::ST_EQL: begin ma = q[31:0]; mb = 32'(cur_h); end
      ssfs_pkg::ST_EQH: begin ma = 32'(q[DW-1:32]); mb = 32'(cur_h); end
      ssfs_pkg::ST_ERH: begin ma = 32'(r); mb = 32'(cur_h); end
      ssfs_pkg::ST_EGL: begin ma = s[31:0]; mb = ssfs_pkg::PI_SIXTH_Q32; end
      ssfs_pkg::ST_EGH: begin ma = 32'(s[SW-1:32]); mb = ssfs_pkg::PI_SIXTH_Q32; end
      ssfs_pkg::ST_EVL: begin ma = g[31:0]; mb = 32'(cur_h); end
      ssfs_pkg::ST_EVH: begin ma = 32'(g[SW-1:32]); mb = 32'(cur_h); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    preg <= ma * mb;
  end

  always_comb begin
    up     = DW'(rt2) + DW'(preg[2*LW-1:0]);
    mag_c  = (up < DW'(rb2)) ? (DW+1)'(DW'(rb2) - up) : (DW+1)'(up - DW'(rb2));
    t_c    = (DW+2)'(tacc) + (DW+2)'(dvd);
    a2_c   = neg ? ((DW+3)'(rb2) - (DW+3)'(hh) - (DW+3)'(t_c))
                 : ((DW+3)'(rb2) - (DW+3)'(hh) + (DW+3)'(t_c));
    full_c = {preg, 32'b0} + 96'(vacc);
    err_c  = (v > vq) ? v - vq : vq - v;
    hit_c  = (err_c <= VW'(volume_tolerance));
    lo_c   = (v < vq) ? cur_h : lo;
    hi_c   = (v < vq) ? hi : cur_h;
    sum_c  = (LW+1)'(lo_c) + (LW+1)'(hi_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ssfs_pkg::ST_IDLE: begin
        if (in_valid) begin
          if ((in_data.func && in_data.volume_in == '0) || height_limit == '0) begin
            state_next = ssfs_pkg::ST_OUT;
          end else begin
            state_next = ssfs_pkg::ST_RB;
          end
        end
      end
      ssfs_pkg::ST_RB:   state_next = ssfs_pkg::ST_RT;
      ssfs_pkg::ST_RT:   state_next = ssfs_pkg::ST_HH;
      ssfs_pkg::ST_HH:   state_next = ssfs_pkg::ST_MAG;
      ssfs_pkg::ST_MAG:  state_next = ssfs_pkg::ST_DIVQ;
      ssfs_pkg::ST_DIVQ: if (div_last) state_next = ssfs_pkg::ST_EHH;
      ssfs_pkg::ST_EHH:  state_next = ssfs_pkg::ST_EQL;
      ssfs_pkg::ST_EQL:  state_next = ssfs_pkg::ST_EQH;
      ssfs_pkg::ST_EQH:  state_next = ssfs_pkg::ST_ERH;
      ssfs_pkg::ST_ERH:  state_next = ssfs_pkg::ST_ELD;
      ssfs_pkg::ST_ELD:  state_next = ssfs_pkg::ST_EDIV;
      ssfs_pkg::ST_EDIV: if (div_last) state_next = ssfs_pkg::ST_EA2;
      ssfs_pkg::ST_EA2:  state_next = ssfs_pkg::ST_ES;
      ssfs_pkg::ST_ES:   state_next = ssfs_pkg::ST_EGL;
      ssfs_pkg::ST_EGL:  state_next = ssfs_pkg::ST_EGH;
      ssfs_pkg::ST_EGH:  state_next = ssfs_pkg::ST_EG;
      ssfs_pkg::ST_EG:   state_next = ssfs_pkg::ST_EVL;
      ssfs_pkg::ST_EVL:  state_next = ssfs_pkg::ST_EVH;
      ssfs_pkg::ST_EVH:  state_next = ssfs_pkg::ST_EV;
      ssfs_pkg::ST_EV:   state_next = ssfs_pkg::ST_CHECK;
      ssfs_pkg::ST_CHECK: begin
        unique case (phase)
          ssfs_pkg::PH_FWD: state_next = ssfs_pkg::ST_OUT;
          ssfs_pkg::PH_MAX: state_next = (vq >= v) ? ssfs_pkg::ST_OUT : ssfs_pkg::ST_EHH;
          ssfs_pkg::PH_BIS: begin
            if (hit_c || pass == PASS_W'(BISECT_PASSES - 1)) begin
              state_next = ssfs_pkg::ST_OUT;
            end else begin
              state_next = ssfs_pkg::ST_EHH;
            end
          end
          default: state_next = ssfs_pkg::ST_OUT;
        endcase
      end
      ssfs_pkg::ST_OUT: if (!out_valid || !out_stall) state_next = ssfs_pkg::ST_IDLE;
      default: state_next = ssfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ssfs_pkg::PH_FWD;
      pass  <= '0;
    end else begin
      unique case (state)
        ssfs_pkg::ST_IDLE: begin
          if (in_valid) begin
            vq        <= in_data.volume_in;
            phase     <= in_data.func ? ssfs_pkg::PH_MAX : ssfs_pkg::PH_FWD;
            clamped_r <= !in_data.func && (in_data.height_in >= height_limit);
            cur_h     <= (in_data.func || in_data.height_in >= height_limit) ?
                         height_limit : in_data.height_in;
            if (in_data.func && in_data.volume_in == '0) begin
              res <= '{fill_volume: '0, fill_height: '0, clamped: 1'b0, converged: 1'b1};
            end else begin
              res <= '{fill_volume: '0, fill_height: '0, clamped: 1'b1, converged: 1'b1};
            end
          end
        end
        ssfs_pkg::ST_RT: rb2 <= preg[2*LW-1:0];
        ssfs_pkg::ST_HH: rt2 <= preg[2*LW-1:0];
        ssfs_pkg::ST_MAG: begin
          neg <= (up < DW'(rb2));
          dvd <= mag_c[DW-1:0];
          rem <= '0;
          cnt <= '0;
        end
        ssfs_pkg::ST_DIVQ, ssfs_pkg::ST_EDIV: begin
          dvd <= dvd_step;
          rem <= rem_step;
          cnt <= cnt + 1'b1;
          if (state == ssfs_pkg::ST_DIVQ && div_last) begin
            q <= dvd_step;
            r <= rem_step;
          end
        end
        ssfs_pkg::ST_EQL: hh <= preg[2*LW-1:0];
        ssfs_pkg::ST_EQH: tacc <= preg[DW:0];
        ssfs_pkg::ST_ERH: tacc <= tacc + {preg[DW-32:0], 32'b0};
        ssfs_pkg::ST_ELD: begin
          dvd <= preg[DW-1:0];
          rem <= '0;
          cnt <= '0;
        end
        ssfs_pkg::ST_EA2: a2 <= a2_c[DW+2] ? '0 : a2_c[DW:0];
        ssfs_pkg::ST_ES:  s <= SW'(3 * (SW'(rb2) + SW'(a2))) + SW'(hh);
        ssfs_pkg::ST_EGH: gacc <= preg;
        ssfs_pkg::ST_EG:  g <= SW'(preg) + SW'(gacc[63:32]);
        ssfs_pkg::ST_EVH: vacc <= preg;
        ssfs_pkg::ST_EV: begin
          if (|full_c[95:VW+2*ssfs_pkg::LENGTH_FRAC_BITS]) begin
            v <= '1;
          end else begin
            v <= full_c[VW+2*ssfs_pkg::LENGTH_FRAC_BITS-1:2*ssfs_pkg::LENGTH_FRAC_BITS];
          end
        end
        ssfs_pkg::ST_CHECK: begin
          unique case (phase)
            ssfs_pkg::PH_FWD: begin
              res <= '{fill_volume: v, fill_height: cur_h, clamped: clamped_r,
                       converged: 1'b1};
            end
            ssfs_pkg::PH_MAX: begin
              if (vq >= v) begin
                res <= '{fill_volume: v, fill_height: height_limit, clamped: 1'b1,
                         converged: 1'b1};
              end else begin
                lo    <= '0;
                hi    <= height_limit;
                cur_h <= height_limit >> 1;
                pass  <= '0;
                phase <= ssfs_pkg::PH_BIS;
              end
            end
            ssfs_pkg::PH_BIS: begin
              res <= '{fill_volume: v, fill_height: cur_h, clamped: 1'b0,
                       converged: hit_c};
              lo    <= lo_c;
              hi    <= hi_c;
              cur_h <= sum_c[LW:1];
              if (pass != PASS_W'(BISECT_PASSES - 1)) begin
                pass <= pass + 1'b1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ssfs_pkg::ST_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
      out_data  <= res;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ssfs_pkg::ST_OUT)
    else $error("Result beat appeared outside the output state.");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != ssfs_pkg::ST_IDLE)
    else $error("Accepted beat did not start the sequencer.");

  assert property (@(posedge clk) disable iff (rst)
    pass <= PASS_W'(BISECT_PASSES - 1))
    else $error("Bisection pass count ran past its limit.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.fill_height <= height_limit)
    else $error("Result height exceeds the height limit.");
`endif

endmodule
`default_nettype wire
